### src/owus_pkg.sv
`default_nettype none

package owus_pkg;

    // request kinds carried in the input beat's tuser
    typedef enum logic [2:0] {
        MODE_ECHO  = 3'd0,
        MODE_LOAD  = 3'd1,
        MODE_RESET = 3'd2,
        MODE_WRITE = 3'd3,
        MODE_READ  = 3'd4,
        MODE_WBIT  = 3'd5,
        MODE_RBIT  = 3'd6
    } mode_t;

    // running operation, one-hot
    typedef enum logic [5:0] {
        TASK_IDLE  = 6'b000001,
        TASK_RESET = 6'b000010,
        TASK_WRITE = 6'b000100,
        TASK_READ  = 6'b001000,
        TASK_WBIT  = 6'b010000,
        TASK_RBIT  = 6'b100000
    } task_t;

    // uart bytes: reset pulse, one or read slot, zero
    localparam logic [7:0] TX_RESET = 8'hF0;
    localparam logic [7:0] TX_ONE   = 8'hFF;
    localparam logic [7:0] TX_ZERO  = 8'h00;
    localparam logic [7:0] RX_ONE   = 8'hFF;

    // result beat fields, msb first so tx_valid lands in bit 0
    typedef struct packed {
        logic       status;
        logic       done_res;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       fast_baud;
        logic [7:0] tx_byte;
        logic       tx_valid;
    } res_t;

    // result in flight from the sequencer to the output stage
    typedef struct packed {
        logic       valid;
        logic       use_mem;
        logic [2:0] bit_sel;
        res_t       res;
    } slot_t;

endpackage

`default_nettype wire

### src/owus_mem.sv
`default_nettype none

module owus_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rdata_reg;

    // write port for load beats
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/owus_ctrl.sv
`default_nettype none

module owus_ctrl
    import owus_pkg::*;
#(
    parameter int MAX_BYTES = 16,
    parameter int AW        = 4,
    parameter int CW        = 5
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          accept,
    input  wire logic [2:0]    mode,
    input  wire logic [7:0]    line_byte,
    input  wire logic [7:0]    data_byte,
    input  wire logic [3:0]    buffer_index,
    input  wire logic [4:0]    byte_count,
    output slot_t              slot,
    output logic               mem_we,
    output logic      [AW-1:0] mem_waddr,
    output logic      [7:0]    mem_wdata,
    output logic               mem_re,
    output logic      [AW-1:0] mem_raddr
);

    task_t          task_reg,  task_next;
    logic [2:0]     bit_reg,   bit_next;
    logic [CW-1:0]  byte_reg,  byte_next;
    logic [CW-1:0]  total_reg, total_next;
    logic [7:0]     shift_reg, shift_next;

    logic [CW-1:0]  cnt_clamp;
    logic [2:0]     bit_inc;
    logic [CW-1:0]  byte_inc;
    logic [7:0]     bit_mask;
    logic [7:0]     shift_upd;
    mode_t          mode_in;

    assign mode_in = mode_t'(mode);

    // count: zero acts as one, saturate at buffer depth
    always_comb begin
        if (byte_count == 5'd0) begin
            cnt_clamp = CW'(1);
        end else if (32'(byte_count) > 32'(MAX_BYTES)) begin
            cnt_clamp = CW'(MAX_BYTES);
        end else begin
            cnt_clamp = CW'(byte_count);
        end
    end

    // slot counters and the read shifter with this echo merged in
    assign bit_inc   = bit_reg + 3'd1;
    assign byte_inc  = byte_reg + CW'(1);
    assign bit_mask  = 8'd1 << bit_reg;
    assign shift_upd = (line_byte == RX_ONE) ? (shift_reg | bit_mask)
                                             : (shift_reg & ~bit_mask);

    // buffer write for load beats
    assign mem_we    = accept && (mode_in == MODE_LOAD)
                       && (32'(buffer_index) < 32'(MAX_BYTES));
    assign mem_waddr = AW'(buffer_index);
    assign mem_wdata = data_byte;
    assign mem_re    = accept && slot.use_mem;

    // sequencer: next state and the result of this beat
    always_comb begin
        task_next  = task_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        total_next = total_reg;
        shift_next = shift_reg;
        slot       = '0;
        mem_raddr  = AW'(byte_reg);

        unique case (mode_in)
            MODE_LOAD: begin
                slot.valid = 1'b0;
            end
            MODE_RESET: begin
                task_next         = TASK_RESET;
                slot.valid        = 1'b1;
                slot.res.tx_valid = 1'b1;
                slot.res.tx_byte  = TX_RESET;
            end
            MODE_WRITE: begin
                task_next          = TASK_WRITE;
                total_next         = cnt_clamp;
                byte_next          = '0;
                bit_next           = 3'd0;
                mem_raddr          = '0;
                slot.valid         = 1'b1;
                slot.use_mem       = 1'b1;
                slot.bit_sel       = 3'd0;
                slot.res.tx_valid  = 1'b1;
                slot.res.fast_baud = 1'b1;
            end
            MODE_READ: begin
                task_next          = TASK_READ;
                total_next         = cnt_clamp;
                byte_next          = '0;
                bit_next           = 3'd0;
                shift_next         = 8'd0;
                slot.valid         = 1'b1;
                slot.res.tx_valid  = 1'b1;
                slot.res.tx_byte   = TX_ONE;
                slot.res.fast_baud = 1'b1;
            end
            MODE_WBIT: begin
                task_next          = TASK_WBIT;
                slot.valid         = 1'b1;
                slot.res.tx_valid  = 1'b1;
                slot.res.tx_byte   = data_byte[0] ? TX_ONE : TX_ZERO;
                slot.res.fast_baud = 1'b1;
            end
            MODE_RBIT: begin
                task_next          = TASK_RBIT;
                slot.valid         = 1'b1;
                slot.res.tx_valid  = 1'b1;
                slot.res.tx_byte   = TX_ONE;
                slot.res.fast_baud = 1'b1;
            end
            MODE_ECHO: begin
                unique case (task_reg)
                    TASK_RESET: begin
                        task_next         = TASK_IDLE;
                        slot.valid        = 1'b1;
                        slot.res.done_res = 1'b1;
                        slot.res.status   = (line_byte == TX_RESET);
                    end
                    TASK_WRITE: begin
                        bit_next           = bit_inc;
                        slot.valid         = 1'b1;
                        slot.res.fast_baud = 1'b1;
                        if (bit_inc == 3'd0) begin
                            byte_next = byte_inc;
                        end
                        if ((bit_inc == 3'd0) && (byte_inc >= total_reg)) begin
                            task_next         = TASK_IDLE;
                            slot.res.done_res = 1'b1;
                        end else begin
                            mem_raddr         = (bit_inc == 3'd0) ? AW'(byte_inc)
                                                                  : AW'(byte_reg);
                            slot.use_mem      = 1'b1;
                            slot.bit_sel      = bit_inc;
                            slot.res.tx_valid = 1'b1;
                        end
                    end
                    TASK_READ: begin
                        bit_next           = bit_inc;
                        shift_next         = shift_upd;
                        slot.valid         = 1'b1;
                        slot.res.fast_baud = 1'b1;
                        if (bit_inc == 3'd0) begin
                            // byte complete
                            shift_next          = 8'd0;
                            byte_next           = byte_inc;
                            slot.res.read_valid = 1'b1;
                            slot.res.read_byte  = shift_upd;
                        end
                        if ((bit_inc == 3'd0) && (byte_inc >= total_reg)) begin
                            task_next         = TASK_IDLE;
                            slot.res.done_res = 1'b1;
                        end else begin
                            slot.res.tx_valid = 1'b1;
                            slot.res.tx_byte  = TX_ONE;
                        end
                    end
                    TASK_WBIT: begin
                        task_next          = TASK_IDLE;
                        slot.valid         = 1'b1;
                        slot.res.fast_baud = 1'b1;
                        slot.res.done_res  = 1'b1;
                    end
                    TASK_RBIT: begin
                        task_next           = TASK_IDLE;
                        slot.valid          = 1'b1;
                        slot.res.fast_baud  = 1'b1;
                        slot.res.read_valid = 1'b1;
                        slot.res.read_byte  = {7'd0, line_byte == RX_ONE};
                        slot.res.done_res   = 1'b1;
                    end
                    default: begin
                        // echo while idle is dropped
                        slot.valid = 1'b0;
                    end
                endcase
            end
            default: begin
                // undefined request kind
                slot.valid = 1'b0;
            end
        endcase

        if (!accept) begin
            slot.valid   = 1'b0;
            slot.use_mem = 1'b0;
        end
    end

    // control registers advance on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_reg  <= TASK_IDLE;
            bit_reg   <= 3'd0;
            byte_reg  <= '0;
            total_reg <= '0;
            shift_reg <= 8'd0;
        end else if (accept) begin
            task_reg  <= task_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            total_reg <= total_next;
            shift_reg <= shift_next;
        end
    end

endmodule

`default_nettype wire

### src/owus_out.sv
`default_nettype none

module owus_out
    import owus_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire slot_t      slot,
    input  wire logic [7:0] rd_data,
    input  wire logic       m_tready,
    output logic            in_ready,
    output logic            m_tvalid,
    output res_t            m_res
);

    logic   s1_valid_reg;
    slot_t  s1_reg;
    logic   m_valid_reg;
    res_t   m_res_reg;
    logic   advance;
    res_t   res_f;

    // stage moves on when the output register is free or being drained
    assign advance  = !m_valid_reg || m_tready;
    assign in_ready = !s1_valid_reg || advance;

    // finish the slot byte from the buffer read
    always_comb begin
        res_f = s1_reg.res;
        if (s1_reg.use_mem) begin
            res_f.tx_byte = rd_data[s1_reg.bit_sel] ? TX_ONE : TX_ZERO;
        end
    end

    // stage one: waits on the buffer read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= slot.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            s1_reg <= slot;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_valid_reg) begin
            m_res_reg <= res_f;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_res    = m_res_reg;

endmodule

`default_nettype wire

### src/onewire_uart_bit_sequencer.sv
`default_nettype none

// channel  dir  ports                      beat contents
// s_       in   s_tvalid s_tready         tuser: mode
//               s_tdata s_tuser           tdata: line_byte data_byte buffer_index byte_count
// m_       out  m_tvalid m_tready m_tdata tdata: tx_valid tx_byte fast_baud read_valid
//                                         read_byte done_res status
//
// one input beat per cycle while s_tready is high; a taken beat passes the sequencer,
// then the write buffer read in stage one, then the output register
// the write buffer is a single memory with a registered read; loads and
// slot reads never meet in the same cycle
// aresetn is synchronous; the buffer keeps its contents over reset
// a stalled m_ side holds stage one, then s_tready drops

module onewire_uart_bit_sequencer
    import owus_pkg::*;
#(
    parameter int MAX_BYTES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] line_byte, [15:8] data_byte, [19:16] buffer_index, [24:20] byte_count
    input  wire logic [31:0] s_tdata,
    // [2:0] mode
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] fast_baud, [10] read_valid,
    // [18:11] read_byte, [19] done_res, [20] status
    output logic      [23:0] m_tdata
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CW = $clog2(MAX_BYTES + 1);

    logic          accept;
    slot_t         slot;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    rd_data;
    res_t          m_res;

    assign accept = s_tvalid && s_tready;

    owus_ctrl #(
        .MAX_BYTES (MAX_BYTES),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .mode         (s_tuser),
        .line_byte    (s_tdata[7:0]),
        .data_byte    (s_tdata[15:8]),
        .buffer_index (s_tdata[19:16]),
        .byte_count   (s_tdata[24:20]),
        .slot         (slot),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr)
    );

    owus_mem #(
        .DEPTH (MAX_BYTES),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    owus_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .slot     (slot),
        .rd_data  (rd_data),
        .m_tready (m_tready),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_res    (m_res)
    );

    assign m_tdata = {3'd0, m_res};

endmodule

`default_nettype wire

### src/owus_checker.sv
`default_nettype none

module owus_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // reset empties the result path
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    // only the three bus bytes go out, and nothing when no send
    a_tx_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] && (m_tdata[8:1] == 8'hF0 || m_tdata[8:1] == 8'hFF
                      || m_tdata[8:1] == 8'h00)) || (!m_tdata[0] && m_tdata[8:1] == 8'h00))
        else $error("bad uart byte");

    // slow baud only for the reset pulse or its end
    a_slow_baud: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[9]) |-> !m_tdata[10]
            && ((m_tdata[0] && m_tdata[8:1] == 8'hF0) || (!m_tdata[0] && m_tdata[19])))
        else $error("slow baud outside a reset");

    // no-device status only ends a reset
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[20]) |-> m_tdata[19] && !m_tdata[9] && !m_tdata[0])
        else $error("status outside the end of a reset");

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

endmodule

bind onewire_uart_bit_sequencer owus_checker u_owus_checker (.*);

`default_nettype wire
